[rtl/core/ecc_pkg.sv]
// ecc_pkg: shared types and constants for the event completion cache
// no dependencies
package ecc_pkg;

  localparam int SLOTS = 32;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int ENTRY_W = 129;

  typedef enum logic [2:0] {
    CMD_RECORD   = 3'd0,
    CMD_FORGET   = 3'd1,
    CMD_QUERY    = 3'd2,
    CMD_COMPLETE = 3'd3,
    CMD_STALE    = 3'd4
  } cmd_t;

  // classified item passed from front to back
  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] event_id;
    logic [63:0] record_tag;
    logic        tag_ok;
    logic [31:0] delta;
  } op_t;

  typedef struct packed {
    logic [63:0] ev;
    logic [63:0] rec;
    logic        done;
  } entry_t;

endpackage

[rtl/core/ecc_ram.sv]
// ecc_ram: generic ram with one write port and one registered read port
// no dependencies
module ecc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/ecc_front.sv]
// ecc_front: accepts items, classifies them and queues them for the back end
// depends on ecc_pkg
module ecc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_cmd,
  input  logic [63:0]         in_event_id,
  input  logic [63:0]         in_record_tag,
  input  logic                in_result_ok,
  input  logic [31:0]         in_delta,
  output logic                q_valid,
  input  logic                q_pop,
  output ecc_pkg::op_t        q_op
);
  import ecc_pkg::*;

  // two entry queue
  op_t        q_mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  op_t        op_in;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_op     = q_mem_r[rp_r];

  always_comb begin
    op_in.cmd        = in_cmd;
    op_in.event_id   = in_event_id;
    op_in.record_tag = in_record_tag;
    op_in.tag_ok     = in_result_ok && (in_record_tag != 64'd0);
    op_in.delta      = in_delta;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (q_pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !q_pop) |=> in_stall)
    else $error("full queue released stall");
endmodule

[rtl/core/ecc_back.sv]
// ecc_back: scans the slot ram one entry per cycle and carries out each operation
// depends on ecc_pkg and ecc_ram
module ecc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_pop,
  input  ecc_pkg::op_t  q_op,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          out_query_needed,
  output logic [63:0]   out_record_out
);
  import ecc_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_WRITE = 6'b001000,
    S_OUT   = 6'b010000,
    S_FWD   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r;
  logic [SLOT_W-1:0] raddr_r;      // address being requested
  logic [SLOT_W-1:0] daddr_r;      // address of data on rdata
  logic              dval_r;       // rdata holds a scanned entry
  logic [CNT_W-1:0]  seen_r;       // entries examined
  logic [SLOT_W-1:0] hit_r;
  entry_t            hit_e_r;
  logic [SLOT_W-1:0] vic_r;
  logic [63:0]       vic_rec_r;
  logic [63:0]       rc_r;
  logic [63:0]       owed_r;
  logic              qn_r;
  logic [63:0]       ro_r;
  logic              ov_r;

  logic              we;
  logic [SLOT_W-1:0] waddr;
  entry_t            wdata, rdata;
  logic              match_ev, match_cmp, last_seen;

  ecc_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr(raddr_r), .rdata
  );

  assign match_ev  = (rdata.ev == op_r.event_id);
  assign match_cmp = (op_r.cmd == CMD_COMPLETE)
                   ? (match_ev && rdata.rec == op_r.record_tag) : match_ev;
  assign last_seen = (seen_r == CNT_W'(SLOTS - 1));

  always_comb begin
    we    = 1'b0;
    waddr = daddr_r;
    wdata = '0;
    if (state_r == S_CLEAR) begin
      we    = 1'b1;
      waddr = raddr_r;
    end else if (state_r == S_SCAN && dval_r && op_r.cmd == CMD_FORGET && match_ev) begin
      we = 1'b1;
    end else if (state_r == S_WRITE) begin
      we    = 1'b1;
      waddr = hit_r;
      wdata = hit_e_r;
    end
  end

  // a new item is only taken once the previous result has left
  assign q_pop            = (state_r == S_IDLE) && q_valid && !ov_r;
  assign out_valid        = ov_r;
  assign out_query_needed = qn_r;
  assign out_record_out   = ro_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (raddr_r == SLOT_W'(SLOTS - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (q_valid && !ov_r) begin
          case (q_op.cmd)
            CMD_RECORD, CMD_FORGET, CMD_QUERY: state_nxt = S_SCAN;
            CMD_COMPLETE: state_nxt = q_op.tag_ok ? S_SCAN : S_OUT;
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_SCAN: begin
        if (dval_r && (last_seen || (match_cmp && op_r.cmd != CMD_FORGET))) begin
          state_nxt = (op_r.cmd == CMD_RECORD || op_r.cmd == CMD_COMPLETE) ? S_WRITE : S_OUT;
        end
      end
      S_WRITE: state_nxt = S_OUT;
      S_OUT:   if (!ov_r || !out_stall) state_nxt = S_FWD;
      S_FWD:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic [63:0] rc_inc;
  logic [32:0] mag;
  logic [64:0] sum;
  assign rc_inc = rc_r + 64'd1;
  assign mag    = 33'h1_0000_0000 - {1'b0, op_r.delta};
  assign sum    = {1'b0, owed_r} + {33'd0, op_r.delta};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      raddr_r <= '0;
      dval_r  <= 1'b0;
      rc_r    <= '0;
      owed_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && (!ov_r || !out_stall)) ov_r <= 1'b1;
      else if (ov_r && !out_stall) ov_r <= 1'b0;
      case (state_r)
        S_CLEAR: raddr_r <= (raddr_r == SLOT_W'(SLOTS - 1)) ? '0 : raddr_r + 1'b1;
        S_IDLE: begin
          raddr_r <= '0;
          daddr_r <= '0;
          dval_r  <= 1'b0;
          seen_r  <= '0;
          vic_r   <= '0;
          if (q_pop) begin
            op_r <= q_op;
            qn_r <= 1'b0;
            ro_r <= '0;
          end
        end
        S_SCAN: begin
          dval_r  <= 1'b1;
          daddr_r <= raddr_r;
          raddr_r <= raddr_r + 1'b1;
          if (dval_r) begin
            seen_r <= seen_r + 1'b1;
            if (seen_r == '0 || rdata.rec < vic_rec_r) begin
              vic_r     <= daddr_r;
              vic_rec_r <= rdata.rec;
            end
            case (op_r.cmd)
              CMD_RECORD: begin
                if (match_ev) begin
                  hit_r   <= daddr_r;
                  hit_e_r <= '{ev: op_r.event_id, rec: rc_inc, done: 1'b0};
                end else if (last_seen) begin
                  hit_r   <= (rdata.rec < vic_rec_r) ? daddr_r : vic_r;
                  hit_e_r <= '{ev: op_r.event_id, rec: rc_inc, done: 1'b0};
                end
                if (match_ev || last_seen) rc_r <= rc_inc;
              end
              CMD_QUERY: begin
                if (match_ev) begin
                  ro_r <= rdata.rec;
                  qn_r <= (owed_r != 64'd0) || !rdata.done;
                end else if (last_seen) begin
                  qn_r <= 1'b1;
                end
              end
              CMD_COMPLETE: begin
                if (match_cmp) begin
                  hit_r   <= daddr_r;
                  hit_e_r <= '{ev: rdata.ev, rec: rdata.rec, done: 1'b1};
                end else if (last_seen) begin
                  hit_r   <= daddr_r;
                  hit_e_r <= rdata;
                end
              end
              default: ;
            endcase
          end
        end
        S_OUT: begin
          if (!ov_r || !out_stall) begin
            if (op_r.cmd == CMD_STALE) begin
              if (!op_r.delta[31]) owed_r <= sum[64] ? '1 : sum[63:0];
              else owed_r <= ({31'd0, mag} >= owed_r) ? '0 : owed_r - {31'd0, mag};
            end
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) (state_r == S_SCAN) |-> !q_pop)
    else $error("pop during scan");
  assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> (ov_r && $stable(ro_r) && $stable(qn_r)))
    else $error("result lost under stall");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> (op_r.cmd == CMD_RECORD || op_r.cmd == CMD_COMPLETE))
    else $error("write-back for wrong command");
endmodule

[rtl/core/event_completion_cache_unit.sv]
// event_completion_cache_unit: top level of the event completion cache
// depends on ecc_pkg, ecc_front, ecc_back
//
// usage
//   input channel: in_valid / in_stall with cmd, event_id, record_tag,
//   result_ok, last_in_batch and delta; one item in gives exactly one
//   result item out on out_valid / out_stall (query_needed, record_out)
//   the front end holds a two item queue, so it keeps taking items while
//   the back end is busy; the back end takes one item at a time
//   record, forget, query and complete scan the slot ram one entry per cycle
//   from slot 0, stopping early on a hit where the operation allows; record
//   and complete then write one entry back; the scan is bound by the single
//   read port of the slot ram; stale, unused commands and a complete
//   with result_ok low or a zero record_tag skip the scan
//   after reset the back end runs a clearing pass over every slot of the
//   slot ram; items queue in the front end meanwhile (two at most)
//   when the receiver stalls, the result stays in the output register and
//   the back end waits, the queue fills and then in_stall rises
//   last_in_batch has no effect
module event_completion_cache_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [63:0] in_event_id,
  input  logic [63:0] in_record_tag,
  input  logic        in_result_ok,
  input  logic        in_last_in_batch,
  input  logic signed [31:0] in_delta,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_query_needed,
  output logic [63:0] out_record_out
);
  import ecc_pkg::*;

  logic q_valid, q_pop;
  op_t  q_op;
  logic unused_batch;

  // batch mark carries no state
  assign unused_batch = in_last_in_batch;

  ecc_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_cmd, .in_event_id, .in_record_tag,
    .in_result_ok, .in_delta(in_delta), .q_valid, .q_pop, .q_op
  );

  ecc_back u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_op, .out_valid, .out_stall,
    .out_query_needed, .out_record_out
  );
endmodule

[dv/tb_top.sv]
// tb_top: self-checking testbench for event_completion_cache_unit
// depends on ecc_pkg and the event_completion_cache_unit rtl
// a predictor of the slot table runs alongside the block; every result is checked in order
`timescale 1ns / 1ps

module tb_top;
  import ecc_pkg::*;

  localparam int NSLOT = 32;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_cmd = '0;
  logic [63:0] in_event_id = '0;
  logic [63:0] in_record_tag = '0;
  logic        in_result_ok = 1'b0;
  logic        in_last_in_batch = 1'b0;
  logic signed [31:0] in_delta = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_query_needed;
  logic [63:0] out_record_out;

  always #1 clk = ~clk;

  event_completion_cache_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .in_event_id(in_event_id), .in_record_tag(in_record_tag),
    .in_result_ok(in_result_ok), .in_last_in_batch(in_last_in_batch),
    .in_delta(in_delta),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_query_needed(out_query_needed), .out_record_out(out_record_out)
  );

  // predicted copy of the slot table and counters
  logic [63:0] tbl_ev [NSLOT];
  logic [63:0] tbl_rec [NSLOT];
  logic        tbl_done [NSLOT];
  logic [63:0] rec_count;
  logic [63:0] owed;

  // expected result items, oldest first
  logic [64:0] pending_results [$];
  int  fails = 0;
  bit  idle_on = 1'b1;
  int  cycles = 0;
  int  stall_left = 0;

  // small pool of handles so that record, query, complete and forget meet
  logic [63:0] ev_pool [8];

  function automatic logic [64:0] predict_item(logic [2:0] cmd, logic [63:0] ev,
                                               logic [63:0] tag, logic ok,
                                               logic signed [31:0] d);
    int victim;
    bit hit;
    logic [63:0] mag;
    logic [64:0] res;
    victim = 0;
    hit = 0;
    res = '0;
    case (cmd)
      CMD_RECORD: begin
        rec_count = rec_count + 64'd1;
        for (int i = 0; i < NSLOT && !hit; i++) begin
          if (tbl_ev[i] == ev) begin
            tbl_rec[i] = rec_count;
            tbl_done[i] = 1'b0;
            hit = 1;
          end else if (tbl_rec[i] < tbl_rec[victim]) begin
            victim = i;
          end
        end
        if (!hit) begin
          tbl_ev[victim] = ev;
          tbl_rec[victim] = rec_count;
          tbl_done[victim] = 1'b0;
        end
      end
      CMD_FORGET: begin
        for (int i = 0; i < NSLOT; i++)
          if (tbl_ev[i] == ev) begin
            tbl_ev[i] = '0;
            tbl_rec[i] = '0;
            tbl_done[i] = 1'b0;
          end
      end
      CMD_QUERY: begin
        res = {1'b1, 64'd0};
        for (int i = 0; i < NSLOT && !hit; i++)
          if (tbl_ev[i] == ev) begin
            res = {(owed != 0) || !tbl_done[i], tbl_rec[i]};
            hit = 1;
          end
      end
      CMD_COMPLETE: begin
        if (ok && tag != 0)
          for (int i = 0; i < NSLOT && !hit; i++)
            if (tbl_ev[i] == ev && tbl_rec[i] == tag) begin
              tbl_done[i] = 1'b1;
              hit = 1;
            end
      end
      CMD_STALE: begin
        if (d >= 0) begin
          mag = {32'd0, d};
          owed = (owed > ~mag) ? '1 : owed + mag;
        end else begin
          mag = 64'd0 - {{32{d[31]}}, d};
          owed = (mag >= owed) ? 64'd0 : owed - mag;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // in_valid stays high from one item to the next; it drops in idle gaps and drains
  task automatic send_item(logic [2:0] cmd, logic [63:0] ev, logic [63:0] tag,
                           logic ok, logic last, logic signed [31:0] d);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_event_id <= ev;
    in_record_tag <= tag;
    in_result_ok <= ok;
    in_last_in_batch <= last;
    in_delta <= d;
    pending_results.push_back(predict_item(cmd, ev, tag, ok, d));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_event();
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    return ev_pool[$urandom_range(0, 7)];
  endfunction

  // extremes of every field, each command, event zero and unused commands
  task automatic test_directed();
    send_item(CMD_QUERY, 64'd0, 64'd0, 1'b0, 1'b0, 32'sd0);
    send_item(CMD_RECORD, 64'd0, 64'd0, 1'b0, 1'b0, 32'sd0);
    send_item(CMD_QUERY, 64'd0, 64'd0, 1'b0, 1'b0, 32'sd0);
    send_item(CMD_RECORD, '1, '1, 1'b1, 1'b1, -32'sd1);
    send_item(CMD_QUERY, '1, 64'd0, 1'b0, 1'b0, 32'sd0);
    send_item(CMD_COMPLETE, '1, 64'd2, 1'b0, 1'b0, 32'sd0);
    send_item(CMD_COMPLETE, '1, 64'd0, 1'b1, 1'b0, 32'sd0);
    send_item(CMD_COMPLETE, '1, 64'd2, 1'b1, 1'b1, 32'sd0);
    send_item(CMD_QUERY, '1, 64'd0, 1'b0, 1'b0, 32'sd0);
    send_item(CMD_STALE, 64'd0, 64'd0, 1'b0, 1'b0, 32'sh7fffffff);
    send_item(CMD_QUERY, '1, 64'd0, 1'b0, 1'b0, 32'sd0);
    send_item(CMD_STALE, 64'd0, 64'd0, 1'b0, 1'b0, 32'sh80000000);
    send_item(CMD_QUERY, '1, 64'd0, 1'b0, 1'b0, 32'sd0);
    send_item(CMD_FORGET, '1, 64'd0, 1'b0, 1'b0, 32'sd0);
    send_item(CMD_QUERY, '1, 64'd0, 1'b0, 1'b0, 32'sd0);
    send_item(3'd5, '1, '1, 1'b1, 1'b1, -32'sd1);
    send_item(3'd6, '1, '1, 1'b1, 1'b0, 32'sd1);
    send_item(3'd7, 64'd0, 64'd0, 1'b0, 1'b1, 32'sd0);
    send_item(CMD_FORGET, 64'd0, 64'd0, 1'b0, 1'b0, 32'sd0);
    // raise owed with the largest positive delta, then lower it by five
    for (int i = 0; i < 4; i++)
      send_item(CMD_STALE, 64'd0, 64'd0, 1'b0, 1'b0, 32'sh7fffffff);
    send_item(CMD_STALE, 64'd0, 64'd0, 1'b0, 1'b0, -32'sd5);
  endtask

  // fill more than the table so that replacement of the oldest slot happens
  task automatic test_replacement();
    for (int i = 0; i < NSLOT + 6; i++)
      send_item(CMD_RECORD, 64'd100 + i, 64'd0, 1'b0, 1'b0, 32'sd0);
    for (int i = 0; i < 8; i++)
      send_item(CMD_QUERY, 64'd100 + i, 64'd0, 1'b0, 1'b0, 32'sd0);
  endtask

  // random mix, mostly record / complete / query on a few live handles
  task automatic test_random(int n);
    logic [2:0] cmd;
    logic [63:0] ev, tag;
    logic signed [31:0] d;
    int pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      ev = pick_event();
      tag = {$urandom, $urandom};
      d = $urandom;
      if (pick < 25) cmd = CMD_RECORD;
      else if (pick < 33) cmd = CMD_FORGET;
      else if (pick < 58) cmd = CMD_QUERY;
      else if (pick < 83) begin
        cmd = CMD_COMPLETE;
        // a well formed completion names one of the latest record counts
        if ($urandom_range(0, 3) != 0) tag = rec_count - $urandom_range(0, 3);
      end else if (pick < 97) begin
        cmd = CMD_STALE;
        if ($urandom_range(0, 1)) d = $signed($urandom_range(0, 6)) - 3;
      end else cmd = 3'($urandom_range(5, 7));
      send_item(cmd, ev, tag, $urandom_range(0, 3) != 0, 1'($urandom), d);
      if (k == n / 2) wait_drained();
    end
  endtask

  // result checker with random receiver stall bursts
  always @(posedge clk) begin
    logic [64:0] exp_res;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item: query_needed %0b record_out %0h",
               out_query_needed, out_record_out);
        fails = fails + 1;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_query_needed !== exp_res[64]) begin
          $error("query_needed: expected %0b actual %0b", exp_res[64], out_query_needed);
          fails = fails + 1;
        end
        if (out_record_out !== exp_res[63:0]) begin
          $error("record_out: expected %0h actual %0h", exp_res[63:0], out_record_out);
          fails = fails + 1;
        end
      end
    end
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= idle_on && (stall_left > 1);
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("event_completion_cache_unit: mismatch");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      tbl_ev[i] = '0;
      tbl_rec[i] = '0;
      tbl_done[i] = 1'b0;
    end
    rec_count = '0;
    owed = '0;
    for (int i = 0; i < 8; i++) ev_pool[i] = {$urandom, $urandom};
    ev_pool[0] = 64'd0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_replacement();
    test_random(800);
    idle_on = 1'b0;
    test_random(100);
    wait_drained();
    repeat (80) @(posedge clk);
    if (fails == 0 && pending_results.size() == 0)
      $display("event_completion_cache_unit: match");
    else
      $display("event_completion_cache_unit: mismatch");
    $finish;
  end

endmodule
